// ===== hw/rtl/cdq_pkg.sv =====
package cdq_pkg;

	typedef enum logic [2:0] {
		OP_PUSH_REAR  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_REAR  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	localparam int EntryW = 32;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] entry_num;
		logic [15:0] entry_time;
	} in_word_t;

	typedef struct packed {
		logic [15:0] out_num;
		logic [15:0] out_time;
		logic [1:0]  status;
		logic        now_empty;
		logic        now_full;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic emit_direct;
		logic emit_read;
	} ctrl_cmd_t;

	typedef struct packed {
		logic needs_read;
	} dp_stat_t;

endpackage

// ===== hw/rtl/cdq_ram.sv =====
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/cdq_datapath.sv =====
module cdq_datapath import cdq_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat,
	input  in_word_t  in_word,
	output out_word_t out_word
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
		return (i == LastIdx) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] i);
		return (i == '0) ? LastIdx : i - 1'b1;
	endfunction

	op_t               op_q;
	logic [EntryW-1:0] entry_q;
	logic [IW-1:0]     front_q, rear_q;
	logic [IW-1:0]     front_n, rear_n;
	logic              none_held, is_full;
	logic              we, re;
	logic [IW-1:0]     waddr, raddr;
	logic [EntryW-1:0] rdata;
	status_t           st;
	out_word_t         out_q;

	assign none_held = (front_q == rear_q);
	assign is_full   = (wrap_inc(rear_q) == front_q);

	always_comb begin
		front_n         = front_q;
		rear_n          = rear_q;
		we              = 1'b0;
		re              = 1'b0;
		waddr           = rear_q;
		raddr           = rear_q;
		st              = ST_OK;
		stat.needs_read = 1'b0;
		unique case (op_q) inside
			OP_PUSH_REAR, OP_PUSH_FRONT: begin
				if (is_full) begin
					st = ST_FULL;
				end else if (op_q == OP_PUSH_REAR) begin
					rear_n = wrap_inc(rear_q);
					waddr  = rear_n;
					we     = 1'b1;
				end else begin
					waddr   = front_q;
					front_n = wrap_dec(front_q);
					we      = 1'b1;
				end
			end
			OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
				if (none_held) begin
					st = ST_EMPTY;
				end else begin
					stat.needs_read = 1'b1;
					re              = 1'b1;
					if (op_q == OP_POP_FRONT || op_q == OP_PEEK_FRONT) begin
						raddr = wrap_inc(front_q);
					end
					if (op_q == OP_POP_FRONT) begin
						front_n = wrap_inc(front_q);
					end
					if (op_q == OP_POP_REAR) begin
						rear_n = wrap_dec(rear_q);
					end
				end
			end
			default: ;	// unused codes leave everything alone
		endcase
	end

	cdq_ram #(
		.WIDTH (EntryW),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we && cmd.exec),
		.waddr (waddr),
		.wdata (entry_q),
		.re    (re && cmd.exec),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
		end else if (cmd.exec) begin
			front_q <= front_n;
			rear_q  <= rear_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(in_word.operation);
			entry_q <= {in_word.entry_time, in_word.entry_num};
		end
		if (cmd.emit_direct) begin
			out_q.out_num   <= '0;
			out_q.out_time  <= '0;
			out_q.status    <= st;
			out_q.now_empty <= (front_n == rear_n);
			out_q.now_full  <= (wrap_inc(rear_n) == front_n);
		end else if (cmd.emit_read) begin
			// pointers already moved in the exec cycle
			out_q.out_num   <= rdata[15:0];
			out_q.out_time  <= rdata[31:16];
			out_q.status    <= ST_OK;
			out_q.now_empty <= none_held;
			out_q.now_full  <= is_full;
		end
	end

	assign out_word = out_q;

endmodule

// ===== hw/rtl/cdq_ctrl.sv =====
module cdq_ctrl import cdq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.emit_direct || cmd.emit_read) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		cmd_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					cmd.load = 1'b1;
					state_n  = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the output register can take the result
				if (out_free) begin
					cmd.exec = 1'b1;
					if (stat.needs_read) begin
						state_n = S_READ;
					end else begin
						cmd.emit_direct = 1'b1;
						state_n         = S_IDLE;
					end
				end
			end
			S_READ: begin
				cmd.emit_read = 1'b1;
				state_n       = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

// ===== hw/rtl/circular_deque.sv =====
// Circular double-ended queue of SLOTS entries, each a 16-bit number and a
// 16-bit time; one slot always stays empty, so it holds at most SLOTS-1.
// Every accepted word (push rear/front, pop front/rear, peek front/rear)
// yields exactly one response word with the entry (zero for a push or a
// refused word), a status and the empty/full flags after the operation. A
// refused push or pop/peek returns an error status and leaves the contents
// alone. A word is taken in the idle state and executed in the exec state,
// and its response word is registered; the next word is taken only once the
// controller is back in idle. A successful pop or peek passes through a read
// state as well for the registered read of the slot memory. Execution waits
// while the response register still holds a result that the consumer has not
// taken, which delays the next acceptance. Slot contents have no reset.
module circular_deque import cdq_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  in_word_t  cmd_word,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_word_t rsp_word
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	cdq_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_word  (cmd_word),
		.out_word (rsp_word)
	);

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_read |-> !rsp_valid)
		else $error("read result lands on an occupied response register");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.emit_direct, cmd.emit_read}))
		else $error("controller issued conflicting commands");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_word.now_empty && rsp_word.now_full))
		else $error("deque reported empty and full at once");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (cmd_stall && !cmd.load))
		else $error("new word taken while one is in flight");

endmodule
